// ===== hdl/sik_pkg.sv =====
// Package for the sorted integer key index.
// Holds table depth, field widths, command and status codes, and the cell control struct.
// No dependencies.
package sik_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CMD_W = 2;
	localparam int ST_W = 2;

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		logic cap_en;
		logic ins_en;
		logic del_en;
	} ctl_t;

endpackage

// ===== hdl/sorted_integer_key_index_top.sv =====
// Sorted integer key index: primary and secondary tables as cell chains.
// Beats pass s1 (compare), s2, output register; in_ready is low while s1 or a
// stalled s2 holds a beat. Insert shifts cells in s1; delete closes the gap on s2_go.
// A full output register holds its beat while the next command is compared.
// arst_n clears control and occupancy flags; both tables come up empty.
// Uses sik_pkg and sik_table.
module sorted_integer_key_index_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sik_pkg::CMD_W-1:0]   command,
	input  logic                        table_select,
	input  logic [sik_pkg::KEY_W-1:0]   key,
	input  logic [sik_pkg::VAL_W-1:0]   entry_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sik_pkg::ST_W-1:0]    status,
	output logic [sik_pkg::VAL_W-1:0]   found_value
);

	logic                      v_s1;
	logic [sik_pkg::CMD_W-1:0] cmd_s1;
	logic                      sel_s1;
	logic [sik_pkg::KEY_W-1:0] key_s1;
	logic [sik_pkg::VAL_W-1:0] val_s1;

	logic                      v_s2;
	logic                      del_s2;
	logic                      sel_s2;
	logic [sik_pkg::ST_W-1:0]  st_s2;
	logic [sik_pkg::VAL_W-1:0] found_s2;

	logic                      out_valid_q;
	logic [sik_pkg::ST_W-1:0]  status_q;
	logic [sik_pkg::VAL_W-1:0] found_q;

	logic s2_go;
	logic accept;
	sik_pkg::ctl_t req_p;
	sik_pkg::ctl_t req_s;
	logic full_p, full_s, hit_p, hit_s;
	logic [sik_pkg::VAL_W-1:0] found_p, found_s;
	logic full_c, hit_c;
	logic [sik_pkg::VAL_W-1:0] found_c;
	logic [sik_pkg::ST_W-1:0] st_c;
	logic [sik_pkg::VAL_W-1:0] fv_c;
	logic del_c;

	assign s2_go    = v_s2 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 && (!v_s2 || s2_go);
	assign accept   = in_valid && in_ready;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_q;

	always_comb begin
		req_p.key    = key_s1;
		req_p.val    = val_s1;
		req_p.cap_en = v_s1 && sel_s1;
		req_p.ins_en = v_s1 && sel_s1 && (cmd_s1 == sik_pkg::CMD_INSERT);
		req_p.del_en = s2_go && del_s2 && sel_s2;
		req_s.key    = key_s1;
		req_s.val    = val_s1;
		req_s.cap_en = v_s1 && !sel_s1;
		req_s.ins_en = v_s1 && !sel_s1 && (cmd_s1 == sik_pkg::CMD_INSERT);
		req_s.del_en = s2_go && del_s2 && !sel_s2;
	end

	sik_table u_primary (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_p),
		.full   (full_p),
		.hit    (hit_p),
		.found  (found_p)
	);

	sik_table u_secondary (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_s),
		.full   (full_s),
		.hit    (hit_s),
		.found  (found_s)
	);

	always_comb begin
		full_c  = sel_s1 ? full_p : full_s;
		hit_c   = sel_s1 ? hit_p : hit_s;
		found_c = sel_s1 ? found_p : found_s;
		st_c    = sik_pkg::ST_NOT_FOUND;
		fv_c    = '0;
		del_c   = 1'b0;
		unique case (cmd_s1)
			sik_pkg::CMD_INSERT: begin
				st_c = full_c ? sik_pkg::ST_FULL : sik_pkg::ST_OK;
			end
			sik_pkg::CMD_LOOKUP, sik_pkg::CMD_DELETE: begin
				if (hit_c) begin
					st_c  = sik_pkg::ST_OK;
					fv_c  = found_c;
					del_c = (cmd_s1 == sik_pkg::CMD_DELETE);
				end
			end
			default: begin
				st_c = sik_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			sel_s1 <= table_select;
			key_s1 <= key;
			val_s1 <= entry_value;
		end
		if (v_s1) begin
			st_s2    <= st_c;
			found_s2 <= fv_c;
			sel_s2   <= sel_s1;
		end
		if (s2_go) begin
			status_q <= st_s2;
			found_q  <= found_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			del_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (v_s1) begin
				v_s2   <= 1'b1;
				del_s2 <= del_c;
			end else if (s2_go) begin
				v_s2   <= 1'b0;
				del_s2 <= 1'b0;
			end
			if (s2_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/sik_cell.sv =====
// One cell of a sorted table chain: holds a key, a value and an occupied flag.
// Compares against the command key and shifts with its neighbors. Uses sik_pkg.
module sik_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sik_pkg::ctl_t             ctl,
	input  logic [sik_pkg::KEY_W-1:0] left_key,
	input  logic [sik_pkg::VAL_W-1:0] left_val,
	input  logic                      left_occ,
	input  logic                      left_ins,
	input  logic                      left_match,
	input  logic [sik_pkg::KEY_W-1:0] right_key,
	input  logic [sik_pkg::VAL_W-1:0] right_val,
	input  logic                      right_occ,
	output logic [sik_pkg::KEY_W-1:0] key_q,
	output logic [sik_pkg::VAL_W-1:0] val_q,
	output logic                      occ_q,
	output logic                      ins,
	output logic                      match,
	output logic                      first,
	output logic [sik_pkg::VAL_W-1:0] pick_val
);

	logic ge;
	logic ge_q;

	always_comb begin
		match    = occ_q && (key_q == ctl.key);
		first    = match && !left_match;
		ins      = !occ_q || (key_q > ctl.key);
		ge       = !occ_q || (key_q >= ctl.key);
		pick_val = first ? val_q : '0;
	end

	always_ff @(posedge clk) begin
		if (ctl.ins_en && ins) begin
			key_q <= left_ins ? left_key : ctl.key;
			val_q <= left_ins ? left_val : ctl.val;
		end else if (ctl.del_en && ge_q) begin
			key_q <= right_key;
			val_q <= right_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			ge_q  <= 1'b0;
		end else begin
			if (ctl.ins_en) begin
				occ_q <= occ_q | left_occ;
			end else if (ctl.del_en && ge_q) begin
				occ_q <= right_occ;
			end
			if (ctl.cap_en) begin
				ge_q <= ge;
			end
		end
	end

endmodule

// ===== hdl/sik_table.sv =====
// One sorted table: a chain of sik_cell and the match reduction.
// Uses sik_pkg and sik_cell.
module sik_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sik_pkg::ctl_t             req,
	output logic                      full,
	output logic                      hit,
	output logic [sik_pkg::VAL_W-1:0] found
);

	localparam int D = sik_pkg::TABLE_DEPTH;

	sik_pkg::ctl_t ctl;
	logic [sik_pkg::KEY_W-1:0] key_a [D];
	logic [sik_pkg::VAL_W-1:0] val_a [D];
	logic [sik_pkg::VAL_W-1:0] pick_a [D];
	logic [D-1:0] occ_a;
	logic [D-1:0] ins_a;
	logic [D-1:0] match_a;
	logic [D-1:0] first_a;

	assign full = occ_a[D-1];

	always_comb begin
		ctl        = req;
		ctl.ins_en = req.ins_en && !occ_a[D-1];
	end

	always_comb begin
		found = '0;
		for (int i = 0; i < D; i++) begin
			found = found | pick_a[i];
		end
		hit = |first_a;
	end

	for (genvar i = 0; i < D; i++) begin : g_cell
		logic [sik_pkg::KEY_W-1:0] lk;
		logic [sik_pkg::VAL_W-1:0] lv;
		logic lo;
		logic li;
		logic lm;
		logic [sik_pkg::KEY_W-1:0] rk;
		logic [sik_pkg::VAL_W-1:0] rv;
		logic ro;

		if (i == 0) begin : g_head
			assign lk = '0;
			assign lv = '0;
			assign lo = 1'b1;
			assign li = 1'b0;
			assign lm = 1'b0;
		end else begin : g_mid
			assign lk = key_a[i-1];
			assign lv = val_a[i-1];
			assign lo = occ_a[i-1];
			assign li = ins_a[i-1];
			assign lm = match_a[i-1];
		end

		if (i == D - 1) begin : g_tail
			assign rk = '0;
			assign rv = '0;
			assign ro = 1'b0;
		end else begin : g_body
			assign rk = key_a[i+1];
			assign rv = val_a[i+1];
			assign ro = occ_a[i+1];
		end

		sik_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left_key   (lk),
			.left_val   (lv),
			.left_occ   (lo),
			.left_ins   (li),
			.left_match (lm),
			.right_key  (rk),
			.right_val  (rv),
			.right_occ  (ro),
			.key_q      (key_a[i]),
			.val_q      (val_a[i]),
			.occ_q      (occ_a[i]),
			.ins        (ins_a[i]),
			.match      (match_a[i]),
			.first      (first_a[i]),
			.pick_val   (pick_a[i])
		);
	end

endmodule

// ===== bench/sorted_integer_key_index_top_tb.sv =====
// Self-checking bench for sorted_integer_key_index_top: queued commands, clocked driver and monitor.
// Mirrors both sorted tables to predict status and found_value for every accepted beat.
// Depends on sik_pkg and the sorted_integer_key_index_top RTL.
`timescale 1ns / 1ps

module sorted_integer_key_index_top_tb;

	localparam logic [sik_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic SEL_PRIMARY = 1'b1;
	localparam logic SEL_SECONDARY = 1'b0;

	localparam int MODE_NONE = 0;
	localparam int MODE_SEND_IDLE = 1;
	localparam int MODE_RECV_STALL = 2;
	localparam int MODE_BOTH = 3;

	localparam int HOLD_CYCLES = 150;

	typedef struct {
		logic [sik_pkg::CMD_W-1:0] op;
		logic                      sel;
		logic [sik_pkg::KEY_W-1:0] k;
		logic [sik_pkg::VAL_W-1:0] v;
		int                        mode;
		bit                        hold;
	} cmd_beat_t;

	typedef struct {
		logic [sik_pkg::ST_W-1:0]  st;
		logic [sik_pkg::VAL_W-1:0] fv;
	} reply_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [sik_pkg::CMD_W-1:0] command = '0;
	logic                      table_select = 1'b0;
	logic [sik_pkg::KEY_W-1:0] key = '0;
	logic [sik_pkg::VAL_W-1:0] entry_value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [sik_pkg::ST_W-1:0]  status;
	logic [sik_pkg::VAL_W-1:0] found_value;

	cmd_beat_t pending_cmds[$];
	reply_t    expected_replies[$];

	logic [sik_pkg::KEY_W-1:0] tbl_keys [2][sik_pkg::TABLE_DEPTH];
	logic [sik_pkg::VAL_W-1:0] tbl_vals [2][sik_pkg::TABLE_DEPTH];
	int                        tbl_count [2];

	int mismatch_cnt = 0;
	int cur_mode = MODE_NONE;
	int hold_ticket = 0;
	int hold_seen = 0;
	int hold_left = 0;

	sorted_integer_key_index_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.table_select(table_select),
		.key(key),
		.entry_value(entry_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found_value(found_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sorted-table mirror: insert after equal keys, lookup/delete hit lowest match
	task automatic index_apply(input logic [sik_pkg::CMD_W-1:0] op, input logic sel,
			input logic [sik_pkg::KEY_W-1:0] k, input logic [sik_pkg::VAL_W-1:0] v,
			output reply_t r);
		int t;
		int n;
		int pos;
		t = sel ? 1 : 0;
		n = tbl_count[t];
		r.st = sik_pkg::ST_NOT_FOUND;
		r.fv = '0;
		if (op == sik_pkg::CMD_INSERT) begin
			if (n >= sik_pkg::TABLE_DEPTH) begin
				r.st = sik_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < n && tbl_keys[t][pos] <= k) pos++;
				for (int i = n; i > pos; i--) begin
					tbl_keys[t][i] = tbl_keys[t][i-1];
					tbl_vals[t][i] = tbl_vals[t][i-1];
				end
				tbl_keys[t][pos] = k;
				tbl_vals[t][pos] = v;
				tbl_count[t] = n + 1;
				r.st = sik_pkg::ST_OK;
			end
		end else if (op == sik_pkg::CMD_LOOKUP || op == sik_pkg::CMD_DELETE) begin
			pos = 0;
			while (pos < n && tbl_keys[t][pos] < k) pos++;
			if (pos < n && tbl_keys[t][pos] == k) begin
				r.st = sik_pkg::ST_OK;
				r.fv = tbl_vals[t][pos];
				if (op == sik_pkg::CMD_DELETE) begin
					for (int i = pos; i + 1 < n; i++) begin
						tbl_keys[t][i] = tbl_keys[t][i+1];
						tbl_vals[t][i] = tbl_vals[t][i+1];
					end
					tbl_count[t] = n - 1;
				end
			end
		end
	endtask

	function automatic bit sender_waits(input int mode);
		if (mode == MODE_SEND_IDLE) return $urandom_range(99) < 86;
		if (mode == MODE_BOTH) return $urandom_range(99) < 22;
		return 1'b0;
	endfunction

	function automatic bit receiver_stalls(input int mode);
		if (mode == MODE_RECV_STALL) return $urandom_range(99) < 86;
		if (mode == MODE_BOTH) return $urandom_range(99) < 22;
		return 1'b0;
	endfunction

	function automatic logic [sik_pkg::KEY_W-1:0] pick_key();
		unique case ($urandom_range(11))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3, 4: return $urandom;
			default: return $urandom_range(40);
		endcase
	endfunction

	task automatic push_cmd(input logic [sik_pkg::CMD_W-1:0] op, input logic sel,
			input logic [sik_pkg::KEY_W-1:0] k, input logic [sik_pkg::VAL_W-1:0] v,
			input int mode);
		cmd_beat_t b;
		b.op = op;
		b.sel = sel;
		b.k = k;
		b.v = v;
		b.mode = mode;
		b.hold = 1'b0;
		pending_cmds.insert(pending_cmds.size(), b);
	endtask

	task automatic push_random(input int count, input int mode,
			input logic [sik_pkg::CMD_W-1:0] bias_op, input logic bias_sel,
			input int bias_pct, input int hold_at);
		logic [sik_pkg::CMD_W-1:0] op;
		logic                      sel;
		int                        r;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < bias_pct) begin
				op = bias_op;
				sel = bias_sel;
			end else begin
				r = $urandom_range(99);
				if (r < 35) op = sik_pkg::CMD_LOOKUP;
				else if (r < 65) op = sik_pkg::CMD_INSERT;
				else if (r < 95) op = sik_pkg::CMD_DELETE;
				else op = CMD_UNUSED;
				sel = 1'($urandom_range(1));
			end
			push_cmd(op, sel, pick_key(), $urandom, mode);
			if (i == hold_at) pending_cmds[$].hold = 1'b1;
		end
	endtask

	// driver: present next beat, mirror each accepted one
	always @(posedge clk) begin : drive_p
		cmd_beat_t b;
		reply_t    r;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				index_apply(command, table_select, key, entry_value, r);
				expected_replies.insert(expected_replies.size(), r);
			end
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() != 0 && !sender_waits(pending_cmds[0].mode)) begin
					b = pending_cmds.pop_front();
					command <= b.op;
					table_select <= b.sel;
					key <= b.k;
					entry_value <= b.v;
					in_valid <= 1'b1;
					cur_mode <= b.mode;
					if (b.hold) hold_ticket <= hold_ticket + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result beat, then pick next out_ready
	always @(posedge clk) begin : monitor_p
		reply_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					$error("unexpected result beat: status %0d found_value %h", status, found_value);
					mismatch_cnt = mismatch_cnt + 1;
				end else begin
					e = expected_replies.pop_front();
					if (status !== e.st) begin
						$error("status: expected %0d, actual %0d", e.st, status);
						mismatch_cnt = mismatch_cnt + 1;
					end
					if (found_value !== e.fv) begin
						$error("found_value: expected %h, actual %h", e.fv, found_value);
						mismatch_cnt = mismatch_cnt + 1;
					end
				end
			end
			if (hold_ticket != hold_seen) begin
				hold_seen <= hold_ticket;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !receiver_stalls(cur_mode);
			end
		end
	end

	initial begin
		for (int t = 0; t < 2; t++) tbl_count[t] = 0;

		// empty tables, unused opcode, extremes, duplicates
		push_cmd(sik_pkg::CMD_LOOKUP, SEL_PRIMARY, '0, '0, MODE_NONE);
		push_cmd(sik_pkg::CMD_DELETE, SEL_SECONDARY, '1, '1, MODE_NONE);
		push_cmd(CMD_UNUSED, SEL_PRIMARY, '1, '1, MODE_NONE);
		push_cmd(sik_pkg::CMD_INSERT, SEL_PRIMARY, '0, '1, MODE_NONE);
		push_cmd(sik_pkg::CMD_INSERT, SEL_PRIMARY, '1, '0, MODE_NONE);
		push_cmd(sik_pkg::CMD_INSERT, SEL_PRIMARY, 32'd5, 32'd1, MODE_NONE);
		push_cmd(sik_pkg::CMD_INSERT, SEL_PRIMARY, 32'd5, 32'd2, MODE_NONE);
		push_cmd(sik_pkg::CMD_INSERT, SEL_PRIMARY, 32'd5, 32'd3, MODE_NONE);
		push_cmd(sik_pkg::CMD_LOOKUP, SEL_PRIMARY, 32'd5, '1, MODE_NONE);
		push_cmd(sik_pkg::CMD_LOOKUP, SEL_SECONDARY, 32'd5, '0, MODE_NONE);
		push_cmd(sik_pkg::CMD_DELETE, SEL_PRIMARY, 32'd5, '0, MODE_NONE);
		push_cmd(sik_pkg::CMD_LOOKUP, SEL_PRIMARY, 32'd5, '0, MODE_NONE);
		push_cmd(sik_pkg::CMD_LOOKUP, SEL_PRIMARY, '0, '0, MODE_NONE);
		push_cmd(sik_pkg::CMD_LOOKUP, SEL_PRIMARY, '1, '0, MODE_NONE);
		push_cmd(sik_pkg::CMD_DELETE, SEL_PRIMARY, '1, '0, MODE_NONE);
		push_cmd(sik_pkg::CMD_LOOKUP, SEL_PRIMARY, '1, '0, MODE_NONE);
		push_cmd(sik_pkg::CMD_INSERT, SEL_SECONDARY, 32'hA5A5_A5A5, 32'h5A5A_5A5A, MODE_NONE);
		push_cmd(sik_pkg::CMD_INSERT, SEL_SECONDARY, 32'h5A5A_5A5A, 32'hA5A5_A5A5, MODE_NONE);
		push_cmd(sik_pkg::CMD_LOOKUP, SEL_SECONDARY, 32'hA5A5_A5A5, '0, MODE_NONE);
		push_cmd(CMD_UNUSED, SEL_SECONDARY, 32'hA5A5_A5A5, '0, MODE_NONE);
		push_cmd(sik_pkg::CMD_LOOKUP, SEL_SECONDARY, 32'hA5A5_A5A5, '0, MODE_NONE);
		push_cmd(sik_pkg::CMD_DELETE, SEL_SECONDARY, 32'd4, '0, MODE_NONE);

		// fill primary past full, with a long output hold along the way
		push_random(340, MODE_NONE, sik_pkg::CMD_INSERT, SEL_PRIMARY, 90, 120);
		push_random(300, MODE_SEND_IDLE, sik_pkg::CMD_LOOKUP, SEL_PRIMARY, 20, -1);
		// drain primary
		push_random(300, MODE_RECV_STALL, sik_pkg::CMD_DELETE, SEL_PRIMARY, 60, -1);
		push_random(300, MODE_BOTH, sik_pkg::CMD_LOOKUP, SEL_SECONDARY, 0, -1);
		// fill secondary past full
		push_random(285, MODE_NONE, sik_pkg::CMD_INSERT, SEL_SECONDARY, 92, 200);

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
